>>> design/tksel_pkg.sv
package tksel_pkg;

  // Field widths fixed by the stream format.
  localparam int SCORE_W   = 16;
  localparam int POS_W     = 16;
  localparam int RANK_W    = 5;
  localparam int CFG_W     = 6;
  localparam int IN_DATA_W = 16;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USED_W = RANK_W + POS_W + SCORE_W;

  // Keep count after reset.
  localparam logic [CFG_W-1:0] KEEP_RESET = CFG_W'(25);

  // Controller states.
  typedef enum logic {
    ST_COLLECT,
    ST_REPORT
  } state_t;

  // One list entry as held by a cell and handed to its neighbors.
  typedef struct packed {
    logic               valid;
    logic [SCORE_W-1:0] score;
    logic [POS_W-1:0]   pos;
  } entry_t;

  // Per-cell control from the controller.
  typedef struct packed {
    logic insert;   // a new score is being inserted this cycle
    logic drain;    // list shifts up one place toward the output
    logic lane_on;  // this cell lies inside the configured keep count
  } cell_ctrl_t;

endpackage

>>> design/tksel_cell.sv
module tksel_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tksel_pkg::cell_ctrl_t               ctrl,
  input  logic [tksel_pkg::SCORE_W-1:0]       new_score,
  input  logic [tksel_pkg::POS_W-1:0]         new_pos,
  input  tksel_pkg::entry_t                   prev_entry,
  input  logic                                take_prev,
  input  tksel_pkg::entry_t                   next_entry,
  output tksel_pkg::entry_t                   entry,
  output logic                                take
);

  tksel_pkg::entry_t entry_r;
  tksel_pkg::entry_t entry_nxt;

  // The new score claims this slot when the slot is empty or strictly smaller.
  // Scores below are sorted, so take rises monotonically along the enabled cells of the chain.
  assign take = ctrl.lane_on &&
                (!entry_r.valid || ($signed(new_score) > $signed(entry_r.score)));

  // Next entry: clear a disabled cell, shift from above, load the new score, drain upward, or hold.
  always_comb begin
    entry_nxt = entry_r;
    if (ctrl.insert) begin
      if (!ctrl.lane_on) begin
        entry_nxt.valid = 1'b0;
      end else if (take_prev) begin
        entry_nxt = prev_entry;
      end else if (take) begin
        entry_nxt.valid = 1'b1;
        entry_nxt.score = new_score;
        entry_nxt.pos   = new_pos;
      end
    end else if (ctrl.drain) begin
      entry_nxt = next_entry;
    end
  end

  // Valid bit is control state and is cleared by reset; the payload needs no reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.score <= entry_nxt.score;
    entry_r.pos   <= entry_nxt.pos;
  end

  assign entry = entry_r;

endmodule

>>> design/streaming_top_k_selector.sv
// Streaming top-k selector.
// Input channel in_*: one signed Q7.8 score per request in in_tdata, in_tlast
// marks the last score of a stream. Scores are numbered from 0 by an internal
// counter that wraps at MAX_ITEMS and restarts after every last score.
// Configuration channel cfg_*: writes the 6-bit keep count k (0 acts as 1,
// values above MAX_KEEP act as MAX_KEEP); write it only while the block idles.
// Output channel out_*: after a last score, one request per kept entry in
// descending order (ties keep the earlier position first), out_tlast on the
// final one. At most min(k, scores seen) entries are reported.
// Throughput: one score per cycle while collecting; a row of MAX_KEEP cells
// inserts each score as it is accepted. After a last score the state register
// enters the report, and each result is then drained into the output register,
// one result per cycle while out_tready is high; the input is held off during
// the report. The output register lets a new stream start while the final
// result still waits.
// Reset clears the list, the position counter and sets k to 25.
// A stalled receiver freezes the report; no result is lost or repeated.
module streaming_top_k_selector #(
  parameter int MAX_KEEP  = 32,
  parameter int MAX_ITEMS = 65536
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Fields from bit 0: logit_value[15:0].
  input  logic [tksel_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic                                 in_tlast,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: rank[4:0], position[20:5], score[36:21], zeros[39:37].
  output logic [tksel_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic [tksel_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready
);

  localparam int CNT_W = $clog2(MAX_ITEMS);

  tksel_pkg::state_t state_r, state_nxt;
  logic [tksel_pkg::CFG_W-1:0]   keep_r;
  logic [CNT_W-1:0]              cnt_r, cnt_nxt;
  logic [tksel_pkg::RANK_W-1:0]  rank_r, rank_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_last_r, out_last_nxt;
  logic [tksel_pkg::OUT_USED_W-1:0] out_data_r, out_data_nxt;

  logic                          in_acc;
  logic                          step;
  logic                          insert;
  logic                          drain;
  logic [tksel_pkg::POS_W-1:0]   cur_pos;
  logic [MAX_KEEP-1:0]           lane_on;

  tksel_pkg::entry_t             ent [MAX_KEEP+1];
  logic [MAX_KEEP:0]             valid_ext;
  logic [MAX_KEEP:0]             take_ext;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == tksel_pkg::ST_COLLECT);
  assign in_acc    = in_tvalid && in_tready;
  assign step      = !out_valid_r || out_tready;
  assign insert    = in_acc;
  assign drain     = (state_r == tksel_pkg::ST_REPORT) && step && ent[0].valid;

  // Keep count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= tksel_pkg::KEEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      keep_r <= cfg_data;
    end
  end

  // Position of the current score, truncated or extended to the field width.
  generate
    if (CNT_W >= tksel_pkg::POS_W) begin : g_pos_trunc
      assign cur_pos = cnt_r[tksel_pkg::POS_W-1:0];
    end else begin : g_pos_ext
      assign cur_pos = {{(tksel_pkg::POS_W-CNT_W){1'b0}}, cnt_r};
    end
  endgenerate

  // Cells below the saturated keep count take part; cell 0 always does.
  genvar g;
  generate
    for (g = 0; g < MAX_KEEP; g++) begin : g_lane
      assign lane_on[g] = (g == 0) || (32'(g) < {{(32-tksel_pkg::CFG_W){1'b0}}, keep_r});
    end
  endgenerate

  // Chain of insertion cells; a dummy empty entry closes the bottom end.
  assign ent[MAX_KEEP]       = '0;
  assign valid_ext[MAX_KEEP] = 1'b0;
  assign take_ext[0]         = 1'b0;

  generate
    for (g = 0; g < MAX_KEEP; g++) begin : g_cell
      tksel_pkg::cell_ctrl_t ctrl;
      tksel_pkg::entry_t     prev_e;

      assign ctrl.insert  = insert;
      assign ctrl.drain   = drain;
      assign ctrl.lane_on = lane_on[g];

      if (g == 0) begin : g_top
        assign prev_e = '0;
      end else begin : g_mid
        assign prev_e = ent[g-1];
      end

      tksel_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_score  (in_tdata[tksel_pkg::SCORE_W-1:0]),
        .new_pos    (cur_pos),
        .prev_entry (prev_e),
        .take_prev  (take_ext[g]),
        .next_entry (ent[g+1]),
        .entry      (ent[g]),
        .take       (take_ext[g+1])
      );

      assign valid_ext[g] = ent[g].valid;
    end
  endgenerate

  // Controller: collect scores, then report the list through the output register.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    rank_nxt      = rank_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      tksel_pkg::ST_COLLECT: begin
        if (in_acc) begin
          if (in_tlast) begin
            cnt_nxt   = '0;
            rank_nxt  = '0;
            state_nxt = tksel_pkg::ST_REPORT;
          end else if (cnt_r == CNT_W'(MAX_ITEMS - 1)) begin
            cnt_nxt = '0;
          end else begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      tksel_pkg::ST_REPORT: begin
        if (drain) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = !valid_ext[1];
          out_data_nxt  = {ent[0].score, ent[0].pos, rank_r};
          rank_nxt      = rank_r + tksel_pkg::RANK_W'(1);
          if (!valid_ext[1]) begin
            state_nxt = tksel_pkg::ST_COLLECT;
          end
        end
      end
      default: begin
        state_nxt = tksel_pkg::ST_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tksel_pkg::ST_COLLECT;
      cnt_r       <= '0;
      rank_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rank_r      <= rank_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_last_r <= out_last_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{(tksel_pkg::OUT_DATA_W-tksel_pkg::OUT_USED_W){1'b0}}, out_data_r};

`ifndef SYNTHESIS
  // Valid entries always form an unbroken run from the top of the list.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_ext[MAX_KEEP:1] & ~valid_ext[MAX_KEEP-1:0]) == '0)
    else $error("list has a gap in its valid entries");

  // A last score always leaves at least one entry to report.
  a_final_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> valid_ext[0])
    else $error("report started with an empty list");

  // While reporting, the head cell holds the next result.
  a_report_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tksel_pkg::ST_REPORT) |-> valid_ext[0])
    else $error("report state with empty head cell");
`endif

endmodule
